[hw/rtl/percentile_select_macros.svh]
// assertion macros used by the percentile select port checker
`ifndef PERCENTILE_SELECT_MACROS_SVH
`define PERCENTILE_SELECT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PCTSEL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PCTSEL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/pctsel_pkg.sv]
// types and constants of the percentile select block
package pctsel_pkg;

	localparam int OP_W      = 2;
	localparam int PCT_W     = 7;
	localparam int PORT_W    = 32;
	localparam int STATUS_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_PLACE,
		S_QRANK,
		S_QREAD,
		S_QDATA,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic lo;
		logic hi;
	} rank_flags_t;

endpackage

[hw/rtl/pctsel_if.sv]
// input and result channel interfaces of the percentile select block
interface pctsel_in_if;
	logic                               valid;
	logic                               ready;
	logic [pctsel_pkg::OP_W-1:0]        operation;
	logic signed [pctsel_pkg::PORT_W-1:0] sample;
	logic [pctsel_pkg::PCT_W-1:0]       percent;
	logic                               last_query;

	modport source (output valid, operation, sample, percent, last_query, input ready);
	modport sink (input valid, operation, sample, percent, last_query, output ready);
endinterface

interface pctsel_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pctsel_pkg::PORT_W-1:0] value;
	logic [pctsel_pkg::STATUS_W-1:0]      status;
	logic                                 last;

	modport source (output valid, value, status, last, input ready);
	modport sink (input valid, value, status, last, output ready);
endinterface

[hw/rtl/pctsel_mem.sv]
// sample store: one write port, one registered read port
module pctsel_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/pctsel_rank.sv]
// rank position pipeline: percent times count, then divide by 100
module pctsel_rank #(
	parameter int CNT_W = 11,
	parameter int IDX_W = 10
) (
	input  logic                           clk,
	input  logic [pctsel_pkg::PCT_W-1:0]   percent,
	input  logic [CNT_W-1:0]               count,
	output pctsel_pkg::rank_flags_t        flags,
	output logic [IDX_W-1:0]               pos
);

	localparam int PN_W = pctsel_pkg::PCT_W + CNT_W;
	localparam int K    = PN_W + 7;
	localparam logic [63:0] RECIP = ((64'd1 << K) + 64'd99) / 64'd100;
	localparam int PR_W = 2 * PN_W + 1;

	logic [PN_W-1:0]  pn_s1;
	logic [CNT_W-1:0] n_s1;
	logic [PN_W:0]    hundred_n;
	logic [PN_W:0]    pn_plus;
	logic [PR_W-1:0]  prod;
	logic [PR_W-1:0]  quot;

	pctsel_pkg::rank_flags_t flags_s2;
	logic [IDX_W-1:0]        pos_s2;

	assign hundred_n = (PN_W+1)'(n_s1) * (PN_W+1)'(100);
	assign pn_plus   = (PN_W+1)'(pn_s1) + (PN_W+1)'(50);
	assign prod      = PR_W'(pn_s1) * PR_W'(RECIP[PN_W:0]);
	assign quot      = prod >> K;

	always_ff @(posedge clk) begin
		pn_s1 <= PN_W'(percent) * PN_W'(count);
		n_s1  <= count;
	end

	always_ff @(posedge clk) begin
		flags_s2.lo <= pn_s1 <= PN_W'(50);
		flags_s2.hi <= pn_plus >= hundred_n;
		pos_s2      <= quot[IDX_W-1:0];
	end

	assign flags = flags_s2;
	assign pos   = pos_s2;

endmodule

[hw/rtl/percentile_select.sv]
// Percentile select over a sorted sample store. Load inserts a sample at its
// sorted place by moving larger entries up one slot per cycle through the
// store's separate read and write ports. A query runs the rank arithmetic
// (percent times count, then divide by 100), a memory read, the capture of
// the read data and the registering of the result. Clear, full and ignored
// items, and queries on an empty store, go straight to the finish state.
// One item is in work at a time; the input channel is ready again once the
// result is handed to the output register, which may still wait on the
// downstream side. The store needs no clearing after reset.
module percentile_select #(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_BITS = 32
) (
	input logic             clk,
	input logic             arst_n,
	pctsel_in_if.sink       in_ch,
	pctsel_out_if.source    out_ch
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int IDX_W = $clog2(MAX_SAMPLES);

	pctsel_pkg::state_t state_q, state_d;
	pctsel_pkg::op_t    op;
	pctsel_pkg::status_t res_status_q;
	pctsel_pkg::rank_flags_t flags;

	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       pos_q;
	logic [SAMPLE_BITS-1:0] samp_q;
	logic [pctsel_pkg::PORT_W-1:0] res_value_q;
	logic                   res_last_q;

	logic                   out_valid_q;
	logic [pctsel_pkg::PORT_W-1:0] out_value_q;
	logic [pctsel_pkg::STATUS_W-1:0] out_status_q;
	logic                   out_last_q;

	logic                   accept;
	logic                   full;
	logic                   empty;
	logic                   greater;
	logic                   out_free;
	logic                   out_load;
	logic [63:0]            samp_ext;
	logic [63:0]            rd_wide;
	logic [IDX_W-1:0]       count_idx;
	logic [IDX_W-1:0]       last_idx;
	logic [IDX_W-1:0]       rank_pos;

	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [SAMPLE_BITS-1:0] wr_data;
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic [SAMPLE_BITS-1:0] rd_data;

	pctsel_mem #(
		.DEPTH (MAX_SAMPLES),
		.WIDTH (SAMPLE_BITS),
		.AW    (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pctsel_rank #(
		.CNT_W (CNT_W),
		.IDX_W (IDX_W)
	) u_rank (
		.clk     (clk),
		.percent (in_ch.percent),
		.count   (count_q),
		.flags   (flags),
		.pos     (rank_pos)
	);

	assign in_ch.ready = state_q == pctsel_pkg::S_IDLE;
	assign accept      = in_ch.valid && in_ch.ready;
	assign op          = pctsel_pkg::op_t'(in_ch.operation);
	assign full        = count_q == CNT_W'(MAX_SAMPLES);
	assign empty       = count_q == '0;
	assign count_idx   = count_q[IDX_W-1:0];
	assign last_idx    = count_idx - IDX_W'(1);
	assign samp_ext    = 64'(in_ch.sample);
	assign rd_wide     = 64'(rd_data);
	assign greater     = $signed(rd_data) > $signed(samp_q);
	assign out_free    = !out_valid_q || out_ch.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pctsel_pkg::S_IDLE: begin
				if (accept) begin
					case (op)
						pctsel_pkg::OP_LOAD: begin
							if (full) begin
								state_d = pctsel_pkg::S_FINISH;
							end else if (empty) begin
								state_d = pctsel_pkg::S_PLACE;
							end else begin
								state_d = pctsel_pkg::S_SHIFT;
							end
						end
						pctsel_pkg::OP_QUERY: begin
							state_d = empty ? pctsel_pkg::S_FINISH : pctsel_pkg::S_QRANK;
						end
						default: state_d = pctsel_pkg::S_FINISH;
					endcase
				end
			end
			pctsel_pkg::S_SHIFT: begin
				if (!greater) begin
					state_d = pctsel_pkg::S_FINISH;
				end else if (pos_q == IDX_W'(1)) begin
					state_d = pctsel_pkg::S_PLACE;
				end
			end
			pctsel_pkg::S_PLACE:  state_d = pctsel_pkg::S_FINISH;
			pctsel_pkg::S_QRANK:  state_d = pctsel_pkg::S_QREAD;
			pctsel_pkg::S_QREAD:  state_d = pctsel_pkg::S_QDATA;
			pctsel_pkg::S_QDATA:  state_d = pctsel_pkg::S_FINISH;
			pctsel_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = pctsel_pkg::S_IDLE;
				end
			end
			default: state_d = pctsel_pkg::S_IDLE;
		endcase
	end

	// memory control and output load
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = pos_q;
		wr_data  = samp_q;
		rd_en    = 1'b0;
		rd_addr  = last_idx;
		out_load = 1'b0;
		case (state_q)
			pctsel_pkg::S_IDLE: begin
				rd_en = accept && (op == pctsel_pkg::OP_LOAD) && !full && !empty;
			end
			pctsel_pkg::S_SHIFT: begin
				wr_en   = 1'b1;
				wr_data = greater ? rd_data : samp_q;
				rd_en   = greater && (pos_q != IDX_W'(1));
				rd_addr = pos_q - IDX_W'(2);
			end
			pctsel_pkg::S_PLACE: begin
				wr_en = 1'b1;
			end
			pctsel_pkg::S_QREAD: begin
				rd_en = 1'b1;
				if (flags.lo) begin
					rd_addr = '0;
				end else if (flags.hi) begin
					rd_addr = last_idx;
				end else begin
					rd_addr = rank_pos;
				end
			end
			pctsel_pkg::S_FINISH: begin
				out_load = out_free;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pctsel_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && op == pctsel_pkg::OP_CLEAR) begin
				count_q <= '0;
			end else if ((state_q == pctsel_pkg::S_SHIFT && !greater)
					|| state_q == pctsel_pkg::S_PLACE) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q      <= samp_ext[SAMPLE_BITS-1:0];
			pos_q       <= count_idx;
			res_value_q <= '0;
			res_last_q  <= (op == pctsel_pkg::OP_QUERY) && in_ch.last_query;
			if (op == pctsel_pkg::OP_LOAD && full) begin
				res_status_q <= pctsel_pkg::ST_FULL;
			end else if (op == pctsel_pkg::OP_QUERY && empty) begin
				res_status_q <= pctsel_pkg::ST_EMPTY;
			end else begin
				res_status_q <= pctsel_pkg::ST_OK;
			end
		end else if (state_q == pctsel_pkg::S_SHIFT && greater) begin
			pos_q <= pos_q - IDX_W'(1);
		end else if (state_q == pctsel_pkg::S_QDATA) begin
			res_value_q <= rd_wide[pctsel_pkg::PORT_W-1:0];
		end
		if (out_load) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
			out_last_q   <= res_last_q;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.value  = out_value_q;
	assign out_ch.status = out_status_q;
	assign out_ch.last   = out_last_q;

endmodule

[hw/rtl/pctsel_check.sv]
// port checker for the percentile select block and its bind
`include "percentile_select_macros.svh"

module pctsel_check (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic [pctsel_pkg::PORT_W-1:0]          value,
	input logic [pctsel_pkg::STATUS_W-1:0]        status,
	input logic                                   last
);

	`PCTSEL_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready, "input ready right after a transfer")
	`PCTSEL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(status) && $stable(last), "stalled result changed")
	`PCTSEL_ASSERT_NOW(a_zero_on_error, out_valid && (status != pctsel_pkg::ST_OK), value == '0, "value not zero on error status")
	`PCTSEL_ASSERT_NOW(a_no_last_on_full, out_valid && (status == pctsel_pkg::ST_FULL), !last, "last set on dropped load")

endmodule

bind percentile_select pctsel_check u_pctsel_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.value     (out_ch.value),
	.status    (out_ch.status),
	.last      (out_ch.last)
);
